@@ src/assert_macros.svh @@
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is asserted.
`define GBR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Implication checked on every rising edge, masked while reset is asserted.
`define GBR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

@@ src/gbr_pkg.sv @@
package gbr_pkg;

  // Coordinate width, fixed by the payload fields
  localparam int unsigned COORD_BITS = 16;
  // Bits in one packed bitmap byte
  localparam int unsigned BYTE_BITS  = 8;
  // Width of the pixel count of one glyph (width * height)
  localparam int unsigned PIX_BITS   = 16;
  // Bit counter width, holds 0 .. BYTE_BITS
  localparam int unsigned CNT_BITS   = 4;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [2:0] {
    OP_SET_CURSOR = 3'd0,
    OP_PUSH       = 3'd1,
    OP_POP        = 3'd2,
    OP_HEADER     = 3'd3,
    OP_BITMAP     = 3'd4
  } op_e;

  // Input transaction
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic signed [7:0]  glyph_x_offset;
    logic signed [7:0]  glyph_y_offset;
    logic [7:0]         x_advance;
    logic [7:0]         bitmap_byte;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               last;
  } out_item_t;

  // Origin stack command
  typedef struct packed {
    logic   push;
    logic   pop;
    coord_t dx;
    coord_t dy;
  } stk_cmd_t;

  // Absolute origin
  typedef struct packed {
    coord_t x;
    coord_t y;
  } origin_t;

  // Serialiser load command
  typedef struct packed {
    logic                 hdr;
    logic                 bmp;
    coord_t               base_x;
    coord_t               base_y;
    logic [7:0]           width;
    logic [7:0]           height;
    logic [BYTE_BITS-1:0] bits;
  } pix_cmd_t;

endpackage

@@ src/gbr_origin_stack.sv @@
module gbr_origin_stack #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbr_pkg::stk_cmd_t cmd_i,
  output gbr_pkg::origin_t  top_o
);

  localparam int unsigned LW = $clog2(STACK_DEPTH);

  // Stack storage; entry zero is never written, and a zero base origin is used in its place
  gbr_pkg::origin_t mem [STACK_DEPTH];

  logic [LW-1:0]    lvl_q, lvl_d;
  gbr_pkg::origin_t top_q, top_d;
  gbr_pkg::origin_t below_q;
  logic [LW-1:0]    rd_addr;
  logic             push_ok, pop_ok;
  gbr_pkg::origin_t pushed;

  assign push_ok = cmd_i.push && (lvl_q != LW'(STACK_DEPTH - 1));
  assign pop_ok  = cmd_i.pop && (lvl_q != '0);

  assign pushed.x = top_q.x + cmd_i.dx;
  assign pushed.y = top_q.y + cmd_i.dy;

  // Next level and top entry; the entry under the top is prefetched
  always_comb begin
    lvl_d = lvl_q;
    top_d = top_q;
    if (push_ok) begin
      lvl_d = lvl_q + LW'(1);
      top_d = pushed;
    end else if (pop_ok) begin
      lvl_d = lvl_q - LW'(1);
      top_d = (lvl_q == LW'(1)) ? '0 : below_q;
    end
  end

  assign rd_addr = (lvl_d == '0) ? '0 : lvl_d - LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
      top_q <= '0;
    end else begin
      lvl_q <= lvl_d;
      top_q <= top_d;
    end
  end

  // Synchronous memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[lvl_q + LW'(1)] <= pushed;
    end
    below_q <= mem[rd_addr];
  end

  assign top_o = top_q;

endmodule

@@ src/gbr_pixel_serializer.sv @@
module gbr_pixel_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbr_pkg::pix_cmd_t  cmd_i,
  output logic               load_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gbr_pkg::out_item_t out_data_o
);

  localparam int unsigned BB = gbr_pkg::BYTE_BITS;
  localparam int unsigned CB = gbr_pkg::CNT_BITS;
  localparam int unsigned PB = gbr_pkg::PIX_BITS;
  localparam int unsigned CW = gbr_pkg::COORD_BITS;

  logic [BB-1:0]     bits_q, bits_d;
  logic [CB-1:0]     cnt_q, cnt_d;
  logic [7:0]        col_q, col_d, row_q, row_d, width_q, width_d;
  logic [PB-1:0]     rem_q, rem_d;
  gbr_pkg::coord_t   base_x_q, base_x_d, base_y_q, base_y_d;
  logic              out_valid_q, out_valid_d;
  gbr_pkg::out_item_t out_q;

  logic          out_free, step, emit, wrap;
  logic [7:0]    col_inc, col_n, row_n;
  logic [PB-1:0] rem_n;
  logic [CB-1:0] used;
  logic [BB-1:0] mask;

  // One bit position per cycle; a set bit needs the output register free
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = (cnt_q != '0) && (!bits_q[BB-1] || out_free);
  assign emit     = step && bits_q[BB-1];

  // Position after this cycle's step
  assign col_inc = col_q + 8'd1;
  assign wrap    = (col_inc == width_q);
  assign col_n   = step ? (wrap ? 8'd0 : col_inc) : col_q;
  assign row_n   = (step && wrap) ? row_q + 8'd1 : row_q;
  assign rem_n   = step ? rem_q - PB'(1) : rem_q;

  // A new header or byte may load as the current byte finishes
  assign load_ok_o = (cnt_q == '0) || ((cnt_q == CB'(1)) && step);

  // Used bits: the lesser of a byte and the pixels left in the glyph
  assign used = (rem_n >= PB'(BB)) ? CB'(BB) : rem_n[CB-1:0];
  assign mask = ~({BB{1'b1}} >> used);

  always_comb begin
    bits_d   = step ? (bits_q << 1) : bits_q;
    cnt_d    = step ? cnt_q - CB'(1) : cnt_q;
    col_d    = col_n;
    row_d    = row_n;
    rem_d    = rem_n;
    width_d  = width_q;
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    if (load_ok_o && cmd_i.hdr) begin
      width_d  = cmd_i.width;
      rem_d    = PB'(cmd_i.width) * PB'(cmd_i.height);
      base_x_d = cmd_i.base_x;
      base_y_d = cmd_i.base_y;
      col_d    = '0;
      row_d    = '0;
    end else if (load_ok_o && cmd_i.bmp) begin
      bits_d = cmd_i.bits & mask;
      cnt_d  = used;
    end
  end

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rem_q       <= '0;
      width_q     <= '0;
      base_x_q    <= '0;
      base_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      rem_q       <= rem_d;
      width_q     <= width_d;
      base_x_q    <= base_x_d;
      base_y_q    <= base_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Byte shift register and output register
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    if (emit) begin
      out_q.pixel_x <= base_x_q + CW'(col_q);
      out_q.pixel_y <= base_y_q + CW'(row_q);
      out_q.last    <= (bits_q[BB-2:0] == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/glyph_bitmap_rasterizer_unit.sv @@
// Glyph bitmap rasteriser. Each input transaction is an opcode with its
// operands; bitmap bytes produce one output transaction per set pixel, one
// per cycle, the final one of each byte flagged by last. Cursor, push, pop
// and unused opcodes are taken every cycle. A bitmap byte occupies the pixel
// serialiser while it steps through its used bits, one per cycle (up to eight,
// none once the glyph is complete), and the next header or byte is taken in
// its final cycle, so a stream of bytes runs without gaps; a set pixel also
// waits while the output register is stalled. Nested origins live in a
// STACK_DEPTH-entry synchronous memory; the entry under the top is kept
// prefetched so pushes and pops run back to back.
module glyph_bitmap_rasterizer_unit #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gbr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gbr_pkg::out_item_t out_data_o
);

  localparam int unsigned CW = gbr_pkg::COORD_BITS;

  gbr_pkg::coord_t   cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  gbr_pkg::stk_cmd_t stk_cmd;
  gbr_pkg::origin_t  top;
  gbr_pkg::pix_cmd_t pix_cmd;
  logic              pix_load_ok;
  logic              is_pix_op, accept;
  logic              op_cursor, op_push, op_pop, op_header, op_bitmap;

  // Opcode decode
  always_comb begin
    op_cursor = 1'b0;
    op_push   = 1'b0;
    op_pop    = 1'b0;
    op_header = 1'b0;
    op_bitmap = 1'b0;
    unique case (in_data_i.opcode)
      gbr_pkg::OP_SET_CURSOR: op_cursor = 1'b1;
      gbr_pkg::OP_PUSH:       op_push   = 1'b1;
      gbr_pkg::OP_POP:        op_pop    = 1'b1;
      gbr_pkg::OP_HEADER:     op_header = 1'b1;
      gbr_pkg::OP_BITMAP:     op_bitmap = 1'b1;
      default: ;
    endcase
  end

  // Header and bitmap transactions wait for the serialiser
  assign is_pix_op  = op_header || op_bitmap;
  assign in_ready_o = is_pix_op ? pix_load_ok : 1'b1;
  assign accept     = in_valid_i && in_ready_o;

  // Origin stack
  assign stk_cmd.push = accept && op_push;
  assign stk_cmd.pop  = accept && op_pop;
  assign stk_cmd.dx   = CW'(in_data_i.coord_x);
  assign stk_cmd.dy   = CW'(in_data_i.coord_y);

  gbr_origin_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (stk_cmd),
    .top_o (top)
  );

  // Glyph base: cursor + top origin + glyph offset
  assign pix_cmd.hdr    = accept && op_header;
  assign pix_cmd.bmp    = accept && op_bitmap;
  assign pix_cmd.base_x = cursor_x_q + top.x
                        + {{(CW-8){in_data_i.glyph_x_offset[7]}}, in_data_i.glyph_x_offset};
  assign pix_cmd.base_y = cursor_y_q + top.y
                        + {{(CW-8){in_data_i.glyph_y_offset[7]}}, in_data_i.glyph_y_offset};
  assign pix_cmd.width  = in_data_i.glyph_width;
  assign pix_cmd.height = in_data_i.glyph_height;
  assign pix_cmd.bits   = in_data_i.bitmap_byte;

  gbr_pixel_serializer u_pix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pix_cmd),
    .load_ok_o  (pix_load_ok),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Cursor
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (accept && op_cursor) begin
      cursor_x_d = CW'(in_data_i.coord_x);
      cursor_y_d = CW'(in_data_i.coord_y);
    end else if (accept && op_header) begin
      cursor_x_d = cursor_x_q + CW'(in_data_i.x_advance);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

endmodule

@@ src/gbr_checker.sv @@
`include "assert_macros.svh"

module gbr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input gbr_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input gbr_pkg::out_item_t out_data_o
);

  logic pix_op;
  logic mid_byte_stall;

  assign pix_op = (in_data_i.opcode == gbr_pkg::OP_HEADER)
               || (in_data_i.opcode == gbr_pkg::OP_BITMAP);

  // Held pixel that still has later set bits of its byte behind it
  assign mid_byte_stall = out_valid_o && !out_ready_i && !out_data_o.last;

  // Cursor, stack and unused opcodes never stall
  `GBR_ASSERT_IMPL(a_ctrl_ready, clk_i, rst_ni, in_valid_i && !pix_op, in_ready_o)

  // A stalled pixel that is not the last of its byte blocks the next header or byte
  `GBR_ASSERT_IMPL(a_hold_pix, clk_i, rst_ni, mid_byte_stall && in_valid_i && pix_op, !in_ready_o)

  // A stalled output transaction holds
  `GBR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

endmodule

bind glyph_bitmap_rasterizer_unit gbr_checker u_gbr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STACK_DEPTH = 8;
  // Opcodes the block has no use for
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  // Cycles with no transaction on either side before giving up
  localparam int unsigned STALL_LIMIT = 3000;
  // Receiver hold-off used to back the block up
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TOTAL_ITEMS = 160;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  gbr_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  gbr_pkg::out_item_t out_data_o;

  int unsigned items_sent = 0;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  bit          held_off = 1'b0;

  // Glyph pixel predictor and the queue of pixels still owed by the block
  class pixel_scoreboard;
    gbr_pkg::coord_t    org_x[STACK_DEPTH];
    gbr_pkg::coord_t    org_y[STACK_DEPTH];
    int unsigned        level;
    gbr_pkg::coord_t    cursor_x, cursor_y;
    gbr_pkg::coord_t    base_x, base_y;
    int unsigned        glyph_w, glyph_h, col, row;
    gbr_pkg::out_item_t pending[$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < STACK_DEPTH; i++) begin
        org_x[i] = '0;
        org_y[i] = '0;
      end
      level    = 0;
      cursor_x = '0;
      cursor_y = '0;
      base_x   = '0;
      base_y   = '0;
      glyph_w  = 0;
      glyph_h  = 0;
      col      = 0;
      row      = 0;
      errors   = 0;
    endfunction

    // Update the state for one accepted transaction and queue its pixels
    function void note_input(gbr_pkg::in_item_t t);
      gbr_pkg::coord_t    nx, ny;
      gbr_pkg::out_item_t pix, held;
      bit                 have;
      logic [7:0]         bits;
      int unsigned        k;
      have = 1'b0;
      case (t.opcode)
        gbr_pkg::OP_SET_CURSOR: begin
          cursor_x = t.coord_x;
          cursor_y = t.coord_y;
        end
        gbr_pkg::OP_PUSH: begin
          // new origin is relative to the current top; ignored when full
          if (level + 1 < STACK_DEPTH) begin
            nx = org_x[level] + gbr_pkg::coord_t'(t.coord_x);
            ny = org_y[level] + gbr_pkg::coord_t'(t.coord_y);
            level++;
            org_x[level] = nx;
            org_y[level] = ny;
          end
        end
        gbr_pkg::OP_POP: begin
          if (level > 0) level--;
        end
        gbr_pkg::OP_HEADER: begin
          glyph_w  = t.glyph_width;
          glyph_h  = t.glyph_height;
          base_x   = cursor_x + org_x[level] + {{8{t.glyph_x_offset[7]}}, t.glyph_x_offset};
          base_y   = cursor_y + org_y[level] + {{8{t.glyph_y_offset[7]}}, t.glyph_y_offset};
          cursor_x = cursor_x + gbr_pkg::coord_t'(t.x_advance);
          col      = 0;
          row      = 0;
        end
        gbr_pkg::OP_BITMAP: begin
          // MSB first, stopping at the end of the glyph
          bits = t.bitmap_byte;
          for (k = 0; k < 8 && glyph_w != 0 && row < glyph_h; k++) begin
            if (bits[7]) begin
              pix.pixel_x = base_x + gbr_pkg::coord_t'(col);
              pix.pixel_y = base_y + gbr_pkg::coord_t'(row);
              pix.last    = 1'b0;
              if (have) pending.push_back(held);
              held = pix;
              have = 1'b1;
            end
            bits = bits << 1;
            col++;
            if (col >= glyph_w) begin
              col = 0;
              row++;
            end
          end
          // final pixel of the byte carries last
          if (have) begin
            held.last = 1'b1;
            pending.push_back(held);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one output transaction with the oldest expected pixel
    function void check_pixel(gbr_pkg::out_item_t got);
      gbr_pkg::out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0d", $time,
                 got.pixel_x, got.pixel_y, got.last);
      end else begin
        want = pending.pop_front();
        if (got.pixel_x !== want.pixel_x) begin
          errors++;
          $display("%0t: pixel_x expected %0d, actual %0d", $time,
                   want.pixel_x, got.pixel_x);
        end
        if (got.pixel_y !== want.pixel_y) begin
          errors++;
          $display("%0t: pixel_y expected %0d, actual %0d", $time,
                   want.pixel_y, got.pixel_y);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0d, actual %0d", $time, want.last, got.last);
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  pixel_scoreboard book = new();

  glyph_bitmap_rasterizer_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, the odd long one, and now and then a run with none
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Every field random, opcode as given
  function automatic gbr_pkg::in_item_t random_item(input logic [2:0] op);
    gbr_pkg::in_item_t t;
    t.opcode         = op;
    t.coord_x        = 16'($urandom);
    t.coord_y        = 16'($urandom);
    t.glyph_width    = 8'($urandom);
    t.glyph_height   = 8'($urandom);
    t.glyph_x_offset = 8'($urandom);
    t.glyph_y_offset = 8'($urandom);
    t.x_advance      = 8'($urandom);
    t.bitmap_byte    = 8'($urandom);
    return t;
  endfunction

  // Offer one transaction, hold it until taken, then maybe idle
  task automatic send_item(input gbr_pkg::in_item_t t);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every owed pixel
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.outstanding() != 0) @(posedge clk_i);
  endtask

  // Monitor: note inputs before checking outputs of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) book.note_input(in_data_i);
      if (out_valid_o && out_ready_i) book.check_pixel(out_data_o);
    end
  end

  // Receiver: random back-pressure, one long hold-off once the stream is busy
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && items_sent >= 45) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held_off = 1'b1;
      end
      stall = pick_gap(recv_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog on cycles with no transaction at all
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    gbr_pkg::in_item_t t;
    int unsigned       i, j, r, needed, nbytes;
    logic [7:0]        w, h;
    bit                paused;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    paused     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte before any glyph header: nothing to draw
    send_item(random_item(gbr_pkg::OP_BITMAP));
    // pop at the base level is ignored
    send_item(random_item(gbr_pkg::OP_POP));
    t = random_item(gbr_pkg::OP_SET_CURSOR);
    t.coord_x = 16'sh7fff;
    t.coord_y = 16'sh8000;
    send_item(t);
    // fill the origin stack, the last push finds it full
    for (i = 0; i < STACK_DEPTH; i++) begin
      t = random_item(gbr_pkg::OP_PUSH);
      t.coord_x = i[0] ? 16'sh8000 : 16'sh7fff;
      t.coord_y = i[0] ? 16'sh7fff : 16'sh8000;
      send_item(t);
    end
    // 3x2 glyph, extreme offsets: one full byte uses six bits, the next is past the end
    t = random_item(gbr_pkg::OP_HEADER);
    t.glyph_width    = 8'd3;
    t.glyph_height   = 8'd2;
    t.glyph_x_offset = -8'sd128;
    t.glyph_y_offset = 8'sd127;
    t.x_advance      = 8'd255;
    send_item(t);
    for (i = 0; i < 2; i++) begin
      t = random_item(gbr_pkg::OP_BITMAP);
      t.bitmap_byte = 8'hff;
      send_item(t);
    end
    // zero width, then zero height: bytes ignored
    t = random_item(gbr_pkg::OP_HEADER);
    t.glyph_width  = 8'd0;
    t.glyph_height = 8'd5;
    send_item(t);
    t = random_item(gbr_pkg::OP_BITMAP);
    t.bitmap_byte = 8'hff;
    send_item(t);
    t = random_item(gbr_pkg::OP_HEADER);
    t.glyph_width  = 8'd5;
    t.glyph_height = 8'd0;
    send_item(t);
    t = random_item(gbr_pkg::OP_BITMAP);
    t.bitmap_byte = 8'ha5;
    send_item(t);
    // widest glyph: clear byte, then sparse bytes
    t = random_item(gbr_pkg::OP_HEADER);
    t.glyph_width    = 8'd255;
    t.glyph_height   = 8'd255;
    t.glyph_x_offset = 8'sd127;
    t.glyph_y_offset = -8'sd128;
    t.x_advance      = 8'd0;
    send_item(t);
    t = random_item(gbr_pkg::OP_BITMAP);
    t.bitmap_byte = 8'h00;
    send_item(t);
    t.bitmap_byte = 8'h81;
    send_item(t);
    t.bitmap_byte = 8'h01;
    send_item(t);
    // unused opcodes do nothing
    for (i = OP_SPARE_FIRST; i <= OP_SPARE_LAST; i++) send_item(random_item(3'(i)));
    drain_results();

    // Random glyph streams with some noise in between
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(random_item(3'($urandom_range(gbr_pkg::OP_SET_CURSOR, OP_SPARE_LAST))));
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          send_item(random_item(gbr_pkg::OP_SET_CURSOR));
        end
        r = $urandom_range(0, 99);
        if (r < 25) begin
          send_item(random_item(gbr_pkg::OP_PUSH));
        end else if (r < 45) begin
          send_item(random_item(gbr_pkg::OP_POP));
        end
        // mostly small glyphs, a few empty or large
        r = $urandom_range(0, 99);
        w = (r < 5) ? 8'd0 : (r < 85) ? 8'($urandom_range(1, 10)) : 8'($urandom_range(11, 255));
        r = $urandom_range(0, 99);
        h = (r < 5) ? 8'd0 : (r < 85) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(7, 255));
        t = random_item(gbr_pkg::OP_HEADER);
        t.glyph_width  = w;
        t.glyph_height = h;
        send_item(t);
        needed = (w * h + 7) / 8;
        nbytes = (needed > 10) ? 10 : needed;
        for (j = 0; j < nbytes; j++) begin
          t = random_item(gbr_pkg::OP_BITMAP);
          r = $urandom_range(0, 9);
          if (r == 0) t.bitmap_byte = 8'h00;
          else if (r == 1) t.bitmap_byte = 8'hff;
          send_item(t);
        end
        // occasionally a stray byte after the glyph is complete
        if (needed <= 10 && $urandom_range(0, 3) == 0) begin
          send_item(random_item(gbr_pkg::OP_BITMAP));
        end
      end
      if (!paused && items_sent >= TOTAL_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (book.errors == 0 && book.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
